@@ hw/rtl/rfb_pkg.sv @@
`timescale 1ns / 1ps

package rfb_pkg;

   // field widths
   localparam int PIX_W      = 16;
   localparam int STEP_W     = 8;
   localparam int CH_W       = 8;              // widened colour channel
   localparam int CH5_W      = 5;              // RGB555 channel
   localparam int CH_SHIFT   = CH_W - CH5_W;
   localparam int NUM_CH     = 3;              // red, green, blue
   localparam int MASK_BIT   = PIX_W - 1;

   // blend factor, 1.12 fixed point
   localparam int FRAC_W     = 12;
   localparam int ONE_W      = FRAC_W + 1;
   localparam logic [ONE_W-1:0] FACTOR_ONE = ONE_W'(13'h1000);
   localparam int PROD_W     = CH_W + ONE_W;
   localparam int RES_LSB    = FRAC_W + CH_SHIFT;

   // divider split: one quotient bit per sub-step
   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS   = FRAC_W / DIV_STAGES;

   localparam int MAX_STEPS_DEFAULT = 255;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_RED   = 2'd0,
      CSR_TARGET_GREEN = 2'd1,
      CSR_TARGET_BLUE  = 2'd2,
      CSR_FADE_STEPS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [CH_W-1:0]   rem;
      logic [FRAC_W-1:0] quo;
   } div_type;

   // one restoring-division step; rem < divisor on entry and exit
   function automatic div_type div_step(input div_type x, input logic [CH_W-1:0] divisor);
      logic [CH_W:0] shifted;
      logic          take;
      div_type       y;
      shifted = {x.rem, 1'b0};
      take    = (shifted >= {1'b0, divisor});
      y.rem   = take ? CH_W'(shifted - {1'b0, divisor}) : shifted[CH_W-1:0];
      y.quo   = {x.quo[FRAC_W-2:0], take};
      return y;
   endfunction

endpackage

@@ hw/rtl/rgb555_fade_blend.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// req       in   req_valid / req_ready         req_pixel_in[15:0], req_step[7:0]
// rsp       out  rsp_valid / rsp_ready         rsp_pixel_out[15:0]
// csr       in   csr_write_enable (no wait)    csr_index[1:0], csr_write_data[7:0]
//
// Seven register stages: prepare, four divider stages (three quotient bits each),
// multiply, sum and pack. One pixel per clock while rsp_ready is high.
// The quotient ((step+1)<<12)/steps sets the depth: 12 restoring steps.
// Reset (synchronous) empties the pipe and loads the reset register values.
// Each stage holds its item while the next cannot take one, so bubbles close up
// under a stall and a transfer is taken as long as any stage is free.

module rgb555_fade_blend #(
   parameter int MAX_STEPS = rfb_pkg::MAX_STEPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rfb_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic [rfb_pkg::STEP_W-1:0]    req_step,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfb_pkg::PIX_W-1:0]     rsp_pixel_out,
   input  logic                          csr_write_enable,
   input  logic [rfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int DIV_LAST   = rfb_pkg::DIV_STAGES;   // last divider stage
   localparam int MUL_IDX    = DIV_LAST + 1;
   localparam int OUT_IDX    = DIV_LAST + 2;
   localparam int NUM_STAGES = OUT_IDX + 1;
   localparam int CH_W       = rfb_pkg::CH_W;
   localparam int CH5_W      = rfb_pkg::CH5_W;
   localparam int PROD_W     = rfb_pkg::PROD_W;
   localparam logic [CH_W-1:0] MAX_CLIP = CH_W'(MAX_STEPS);

   // configuration registers
   logic [CH_W-1:0] target_ff [rfb_pkg::NUM_CH];   // red, green, blue
   logic [CH_W-1:0] fade_steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < rfb_pkg::NUM_CH; c++) begin
            target_ff[c] <= '0;
         end
         fade_steps_ff <= CH_W'(1);
      end else if (csr_write_enable) begin
         unique case (rfb_pkg::csr_idx_type'(csr_index))
            rfb_pkg::CSR_TARGET_RED:   target_ff[0]  <= csr_write_data;
            rfb_pkg::CSR_TARGET_GREEN: target_ff[1]  <= csr_write_data;
            rfb_pkg::CSR_TARGET_BLUE:  target_ff[2]  <= csr_write_data;
            rfb_pkg::CSR_FADE_STEPS:   fade_steps_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // valid / ready chain; a stage takes a new item when empty or draining
   logic [NUM_STAGES-1:0] valid_ff, valid_in, stage_ready;

   always_comb begin
      stage_ready[OUT_IDX] = !valid_ff[OUT_IDX] || rsp_ready;
      for (int k = OUT_IDX - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[OUT_IDX];

   // prepare and divider stages: index 0 prepares, 1..DIV_LAST divide
   logic [rfb_pkg::PIX_W-1:0] pix_ff     [NUM_STAGES-1];
   logic                      sat_ff     [NUM_STAGES-1];
   logic [CH_W-1:0]           divisor_ff [DIV_LAST+1];
   rfb_pkg::div_type          div_ff     [DIV_LAST+1];
   rfb_pkg::div_type          div_in     [DIV_LAST+1];
   logic [CH_W-1:0]           divisor_in;
   logic                      sat_in;

   always_comb begin
      logic [CH_W:0]    step_inc;
      rfb_pkg::div_type tmp;
      // zero steps acts as one; the divisor saturates at MAX_STEPS
      priority if (fade_steps_ff == '0) begin
         divisor_in = CH_W'(1);
      end else if (int'(fade_steps_ff) > MAX_STEPS) begin
         divisor_in = MAX_CLIP;
      end else begin
         divisor_in = fade_steps_ff;
      end
      step_inc   = {1'b0, req_step} + (CH_W+1)'(1);
      // last step or beyond: straight to the target colour
      sat_in     = (step_inc >= {1'b0, divisor_in});
      // otherwise step+1 < divisor, so the partial remainder starts in range
      div_in[0].rem = step_inc[CH_W-1:0];
      div_in[0].quo = '0;
      for (int k = 1; k <= DIV_LAST; k++) begin
         tmp = div_ff[k-1];
         for (int j = 0; j < rfb_pkg::DIV_BITS; j++) begin
            tmp = rfb_pkg::div_step(tmp, divisor_ff[k-1]);
         end
         div_in[k] = tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         pix_ff[0]     <= req_pixel_in;
         sat_ff[0]     <= sat_in;
         divisor_ff[0] <= divisor_in;
         div_ff[0]     <= div_in[0];
      end
      for (int k = 1; k <= DIV_LAST; k++) begin
         if (stage_ready[k]) begin
            pix_ff[k]     <= pix_ff[k-1];
            sat_ff[k]     <= sat_ff[k-1];
            divisor_ff[k] <= divisor_ff[k-1];
            div_ff[k]     <= div_in[k];
         end
      end
   end

   // multiply stage: src*(1-f) and target*f per channel
   logic [PROD_W-1:0]         psrc_ff [rfb_pkg::NUM_CH];
   logic [PROD_W-1:0]         ptgt_ff [rfb_pkg::NUM_CH];
   logic [PROD_W-1:0]         psrc_in [rfb_pkg::NUM_CH];
   logic [PROD_W-1:0]         ptgt_in [rfb_pkg::NUM_CH];
   logic [rfb_pkg::ONE_W-1:0] inv_factor;

   always_comb begin
      logic [CH_W-1:0] src8;
      inv_factor = rfb_pkg::FACTOR_ONE - {1'b0, div_ff[DIV_LAST].quo};
      for (int c = 0; c < rfb_pkg::NUM_CH; c++) begin
         src8       = {pix_ff[DIV_LAST][c*CH5_W +: CH5_W], {rfb_pkg::CH_SHIFT{1'b0}}};
         psrc_in[c] = PROD_W'(src8) * PROD_W'(inv_factor);
         ptgt_in[c] = PROD_W'(target_ff[c]) * PROD_W'(div_ff[DIV_LAST].quo);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[MUL_IDX]) begin
         pix_ff[MUL_IDX] <= pix_ff[DIV_LAST];
         sat_ff[MUL_IDX] <= sat_ff[DIV_LAST];
         for (int c = 0; c < rfb_pkg::NUM_CH; c++) begin
            psrc_ff[c] <= psrc_in[c];
            ptgt_ff[c] <= ptgt_in[c];
         end
      end
   end

   // sum, take the top five bits of each 8-bit result and repack
   logic [rfb_pkg::PIX_W-1:0] pixel_out_ff, pixel_out_in;

   always_comb begin
      logic [PROD_W-1:0]         sum;
      logic [rfb_pkg::PIX_W-1:0] blended;
      logic [rfb_pkg::PIX_W-1:0] packed_tgt;
      blended    = '0;
      packed_tgt = '0;
      blended[rfb_pkg::MASK_BIT]    = pix_ff[MUL_IDX][rfb_pkg::MASK_BIT];
      packed_tgt[rfb_pkg::MASK_BIT] = 1'b1;
      for (int c = 0; c < rfb_pkg::NUM_CH; c++) begin
         sum = psrc_ff[c] + ptgt_ff[c];
         blended[c*CH5_W +: CH5_W]    = sum[rfb_pkg::RES_LSB +: CH5_W];
         packed_tgt[c*CH5_W +: CH5_W] = target_ff[c][CH_W-1 -: CH5_W];
      end
      // transparent pixel wins over everything
      priority if (pix_ff[MUL_IDX] == '0) begin
         pixel_out_in = '0;
      end else if (sat_ff[MUL_IDX]) begin
         pixel_out_in = packed_tgt;
      end else begin
         pixel_out_in = blended;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[OUT_IDX]) begin
         pixel_out_ff <= pixel_out_in;
      end
   end

   assign rsp_pixel_out = pixel_out_ff;

endmodule

@@ hw/rtl/rfb_checker.sv @@
`timescale 1ns / 1ps

module rfb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rfb_pkg::PIX_W-1:0]  rsp_pixel_out
);

   // seven stages: a transfer taken after reset must pass all of them
   // before it can show at the output
   localparam int FILL_CYCLES = 6;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result changed or dropped");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

   // a free output stage frees every stage upstream
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output side drains");

   // nothing comes out of an empty pipe before it can have filled
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid [*FILL_CYCLES])
      else $error("result with no transfer behind it");

   // an offered transfer stays offered until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("input withdrawn before transfer");

endmodule

bind rgb555_fade_blend rfb_checker u_rfb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out)
);
